[rtl/hyst_pkg.sv]
// Shared types and constants for the hysteresis thermostat.
// Holds command codes, register indexes, config and result structs.
// No dependencies; compiled before every other file.
package hyst_pkg;

  // Timer width default and limits of the config fields
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int TEMP_W          = 16;
  localparam int BAND_W          = 12;
  localparam int MIN_W           = 17;
  localparam int LIMIT_W         = 18;
  localparam int CMD_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ON     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OFF    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_AUTO   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF = 3'd4;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] TARGET_RST = 16'sd320;
  localparam logic [BAND_W-1:0]        BAND_RST   = 12'd16;
  localparam logic                     MODE_RST   = 1'b1;
  localparam logic signed [MIN_W-1:0]  MIN_RST    = -17'sd1;

  // Unit mode value for cooling (any other value heats)
  localparam logic MODE_COOL = 1'b0;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic [BAND_W-1:0]        band_half_width;
    logic                     unit_mode;
    logic signed [MIN_W-1:0]  min_on_seconds;
    logic signed [MIN_W-1:0]  min_off_seconds;
  } cfg_t;

  typedef struct packed {
    logic drive_on;
    logic switched_on;
    logic switched_off;
    logic refused;
    logic held;
  } result_t;

endpackage

[rtl/hyst_in_if.sv]
// Input channel of the thermostat: command and temperature request.
// Uses hyst_pkg for field widths.
interface hyst_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [hyst_pkg::CMD_W-1:0]            cmd;
  logic signed [hyst_pkg::TEMP_W-1:0]    temperature;

  modport source (output valid, output cmd, output temperature, input ready);
  modport sink   (input valid, input cmd, input temperature, output ready);
endinterface

[rtl/hyst_out_if.sv]
// Result channel of the thermostat: drive state and event flags.
// No package dependencies.
interface hyst_out_if;
  logic valid;
  logic ready;
  logic drive_on;
  logic switched_on;
  logic switched_off;
  logic refused;
  logic held;

  modport source (output valid, output drive_on, output switched_on,
                  output switched_off, output refused, output held, input ready);
  modport sink   (input valid, input drive_on, input switched_on,
                  input switched_off, input refused, input held, output ready);
endinterface

[rtl/hyst_cfg_if.sv]
// Configuration write channel: register index and write data.
// Uses hyst_pkg for field widths.
interface hyst_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hyst_pkg::CFG_IDX_W-1:0]  index;
  logic [hyst_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/hyst_core.sv]
// Next-state and result logic for one thermostat request.
// Pure combinational; uses hyst_pkg types and command codes.
module hyst_core #(
  parameter int TIMER_WIDTH = hyst_pkg::TIMER_WIDTH_DEF
) (
  input  hyst_pkg::cfg_t                       cfg,
  input  logic [hyst_pkg::CMD_W-1:0]           cmd,
  input  logic signed [hyst_pkg::TEMP_W-1:0]   temperature,
  input  logic                                 running,
  input  logic                                 manual_hold,
  input  logic [TIMER_WIDTH-1:0]               secs_since_on,
  input  logic [TIMER_WIDTH-1:0]               secs_since_off,
  output logic                                 running_next,
  output logic                                 manual_hold_next,
  output logic [TIMER_WIDTH-1:0]               secs_since_on_next,
  output logic [TIMER_WIDTH-1:0]               secs_since_off_next,
  output hyst_pkg::result_t                    res
);

  localparam int CMP_W = ((TIMER_WIDTH > hyst_pkg::MIN_W) ?
                          TIMER_WIDTH : hyst_pkg::MIN_W) + 1;
  localparam int LW    = hyst_pkg::LIMIT_W;

  logic signed [LW-1:0]    temp_x;
  logic signed [LW-1:0]    upper;
  logic signed [LW-1:0]    lower;
  logic                    above_upper;
  logic                    below_lower;
  logic                    cooling;
  logic                    want_on;
  logic                    want_off;
  logic signed [CMP_W-1:0] on_cnt_x;
  logic signed [CMP_W-1:0] off_cnt_x;
  logic signed [CMP_W-1:0] min_on_x;
  logic signed [CMP_W-1:0] min_off_x;
  logic                    on_allowed;
  logic                    off_allowed;
  logic [TIMER_WIDTH-1:0]  on_inc;
  logic [TIMER_WIDTH-1:0]  off_inc;
  logic                    sw_on;
  logic                    sw_off;
  logic                    refused;

  // Hysteresis limits, exact in 18 bits
  assign temp_x = {{(LW-hyst_pkg::TEMP_W){temperature[hyst_pkg::TEMP_W-1]}}, temperature};
  assign upper  = {{(LW-hyst_pkg::TEMP_W){cfg.target_temp[hyst_pkg::TEMP_W-1]}},
                   cfg.target_temp}
                + $signed({{(LW-hyst_pkg::BAND_W){1'b0}}, cfg.band_half_width});
  assign lower  = {{(LW-hyst_pkg::TEMP_W){cfg.target_temp[hyst_pkg::TEMP_W-1]}},
                   cfg.target_temp}
                - $signed({{(LW-hyst_pkg::BAND_W){1'b0}}, cfg.band_half_width});
  assign above_upper = temp_x > upper;
  assign below_lower = temp_x < lower;

  // Direction of the unit decides which limit turns it on
  assign cooling  = (cfg.unit_mode == hyst_pkg::MODE_COOL);
  assign want_on  = !running && (cooling ? above_upper : below_lower);
  assign want_off = running && (cooling ? below_lower : above_upper);

  // Anti-short-cycle check: counter (unsigned) against minimum (signed)
  assign on_cnt_x  = {{(CMP_W-TIMER_WIDTH){1'b0}}, secs_since_on};
  assign off_cnt_x = {{(CMP_W-TIMER_WIDTH){1'b0}}, secs_since_off};
  assign min_on_x  = {{(CMP_W-hyst_pkg::MIN_W){cfg.min_on_seconds[hyst_pkg::MIN_W-1]}},
                      cfg.min_on_seconds};
  assign min_off_x = {{(CMP_W-hyst_pkg::MIN_W){cfg.min_off_seconds[hyst_pkg::MIN_W-1]}},
                      cfg.min_off_seconds};
  assign on_allowed  = off_cnt_x > min_off_x;
  assign off_allowed = on_cnt_x > min_on_x;

  // Saturating seconds counters
  assign on_inc  = (&secs_since_on)  ? secs_since_on  : secs_since_on + 1'b1;
  assign off_inc = (&secs_since_off) ? secs_since_off : secs_since_off + 1'b1;

  // Command decode
  always_comb begin
    running_next        = running;
    manual_hold_next    = manual_hold;
    secs_since_on_next  = secs_since_on;
    secs_since_off_next = secs_since_off;
    sw_on               = 1'b0;
    sw_off              = 1'b0;
    refused             = 1'b0;
    case (cmd)
      hyst_pkg::CMD_SAMPLE: begin
        if (!manual_hold) begin
          if (want_on) begin
            if (on_allowed) begin
              running_next       = 1'b1;
              secs_since_on_next = '0;
              sw_on              = 1'b1;
            end else begin
              refused = 1'b1;
            end
          end else if (want_off) begin
            if (off_allowed) begin
              running_next        = 1'b0;
              secs_since_off_next = '0;
              sw_off              = 1'b1;
            end else begin
              refused = 1'b1;
            end
          end
        end
      end
      hyst_pkg::CMD_TICK: begin
        secs_since_on_next  = on_inc;
        secs_since_off_next = off_inc;
      end
      hyst_pkg::CMD_ON: begin
        manual_hold_next   = 1'b1;
        sw_on              = !running;
        running_next       = 1'b1;
        secs_since_on_next = '0;
      end
      hyst_pkg::CMD_OFF: begin
        manual_hold_next    = 1'b1;
        sw_off              = running;
        running_next        = 1'b0;
        secs_since_off_next = '0;
      end
      hyst_pkg::CMD_AUTO: begin
        manual_hold_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign res.drive_on     = running_next;
  assign res.switched_on  = sw_on;
  assign res.switched_off = sw_off;
  assign res.refused      = refused;
  assign res.held         = manual_hold_next;

endmodule

[rtl/hysteresis_thermostat_min_cycle_top.sv]
// Hysteresis thermostat with minimum on/off times, top level.
// A request accepted into the input register moves into the result register once
// the result register is empty or is being read. Throughput: one request per cycle
// while the output is not stalled; a stalled output holds one result. Reset (rst,
// synchronous): config to defaults, drive off, automatic mode, secs_since_on = 1,
// secs_since_off = 0, both registers empty.
module hysteresis_thermostat_min_cycle_top #(
  parameter int TIMER_WIDTH = hyst_pkg::TIMER_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  hyst_in_if.sink    in_ch,
  hyst_out_if.source out_ch,
  hyst_cfg_if.sink   cfg_ch
);

  hyst_pkg::cfg_t                      cfg;
  logic                                in_valid;
  logic [hyst_pkg::CMD_W-1:0]          cmd;
  logic signed [hyst_pkg::TEMP_W-1:0]  temperature;
  logic                                out_valid;
  hyst_pkg::result_t                   res;
  hyst_pkg::result_t                   res_next;
  logic                                running;
  logic                                manual_hold;
  logic [TIMER_WIDTH-1:0]              secs_since_on;
  logic [TIMER_WIDTH-1:0]              secs_since_off;
  logic                                running_next;
  logic                                manual_hold_next;
  logic [TIMER_WIDTH-1:0]              secs_since_on_next;
  logic [TIMER_WIDTH-1:0]              secs_since_off_next;
  logic                                advance;

  // Configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp     <= hyst_pkg::TARGET_RST;
      cfg.band_half_width <= hyst_pkg::BAND_RST;
      cfg.unit_mode       <= hyst_pkg::MODE_RST;
      cfg.min_on_seconds  <= hyst_pkg::MIN_RST;
      cfg.min_off_seconds <= hyst_pkg::MIN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hyst_pkg::REG_TARGET:  cfg.target_temp     <= cfg_ch.data[hyst_pkg::TEMP_W-1:0];
        hyst_pkg::REG_BAND:    cfg.band_half_width <= cfg_ch.data[hyst_pkg::BAND_W-1:0];
        hyst_pkg::REG_MODE:    cfg.unit_mode       <= cfg_ch.data[0];
        hyst_pkg::REG_MIN_ON:  cfg.min_on_seconds  <= cfg_ch.data[hyst_pkg::MIN_W-1:0];
        hyst_pkg::REG_MIN_OFF: cfg.min_off_seconds <= cfg_ch.data[hyst_pkg::MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request moves from the input register into the result register
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd         <= in_ch.cmd;
      temperature <= in_ch.temperature;
    end
  end

  hyst_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .cfg                 (cfg),
    .cmd                 (cmd),
    .temperature         (temperature),
    .running             (running),
    .manual_hold         (manual_hold),
    .secs_since_on       (secs_since_on),
    .secs_since_off      (secs_since_off),
    .running_next        (running_next),
    .manual_hold_next    (manual_hold_next),
    .secs_since_on_next  (secs_since_on_next),
    .secs_since_off_next (secs_since_off_next),
    .res                 (res_next)
  );

  // Controller state, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      manual_hold    <= 1'b0;
      secs_since_on  <= TIMER_WIDTH'(1);
      secs_since_off <= '0;
    end else if (advance) begin
      running        <= running_next;
      manual_hold    <= manual_hold_next;
      secs_since_on  <= secs_since_on_next;
      secs_since_off <= secs_since_off_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.drive_on     = res.drive_on;
  assign out_ch.switched_on  = res.switched_on;
  assign out_ch.switched_off = res.switched_off;
  assign out_ch.refused      = res.refused;
  assign out_ch.held         = res.held;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hysteresis_thermostat_min_cycle_top.
// Depends on hyst_pkg and the hyst_in_if, hyst_out_if and hyst_cfg_if interfaces.
module tb_top;

  localparam int TMR_W = hyst_pkg::TIMER_WIDTH_DEF;
  localparam logic [TMR_W-1:0] TMR_MAX = '1;
  localparam logic MODE_HEAT = 1'b1;
  localparam logic [hyst_pkg::CMD_W-1:0] CMD_LAST_UNDEF = 3'd7;
  localparam logic signed [hyst_pkg::MIN_W-1:0] NO_MIN = -17'sd1;
  localparam logic signed [hyst_pkg::MIN_W-1:0] MIN_TOP = 17'sd65534;

  logic clk;
  logic rst;

  hyst_in_if  in_ch ();
  hyst_out_if out_ch ();
  hyst_cfg_if cfg_ch ();

  hysteresis_thermostat_min_cycle_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the thermostat: config and state
  hyst_pkg::cfg_t   cfg_m;
  logic             drive_m;
  logic             hold_m;
  logic [TMR_W-1:0] secs_on_m;
  logic [TMR_W-1:0] secs_off_m;

  hyst_pkg::result_t pending_results[$];
  hyst_pkg::result_t expected_r;
  hyst_pkg::result_t got_r;

  // Idle controls shared by the sender, the receiver and the tests
  bit src_idle;
  bit sink_idle;
  int sink_hold;

  int n_errors;
  int n_sent;
  int n_checked;
  int n_sw_on;
  int n_sw_off;
  int n_refused;
  int n_held;

  string field_names[5] = '{"held", "refused", "switched_off", "switched_on", "drive_on"};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // Next thermostat state and result for one request
  function automatic hyst_pkg::result_t thermo_predict(
      input logic [hyst_pkg::CMD_W-1:0] cmd,
      input logic signed [hyst_pkg::TEMP_W-1:0] temp);
    hyst_pkg::result_t r;
    int      t_val;
    int      upper;
    int      lower;
    bit      cooling;
    bit      want_on;
    bit      want_off;
    r = '0;
    case (cmd)
      hyst_pkg::CMD_SAMPLE: begin
        if (!hold_m) begin
          t_val    = int'(temp);
          upper    = int'($signed(cfg_m.target_temp)) + int'(cfg_m.band_half_width);
          lower    = int'($signed(cfg_m.target_temp)) - int'(cfg_m.band_half_width);
          cooling  = (cfg_m.unit_mode == hyst_pkg::MODE_COOL);
          want_on  = !drive_m && (cooling ? (t_val > upper) : (t_val < lower));
          want_off = drive_m && (cooling ? (t_val < lower) : (t_val > upper));
          if (want_on) begin
            if (int'({1'b0, secs_off_m}) > int'($signed(cfg_m.min_off_seconds))) begin
              drive_m       = 1'b1;
              secs_on_m     = '0;
              r.switched_on = 1'b1;
            end else begin
              r.refused = 1'b1;
            end
          end else if (want_off) begin
            if (int'({1'b0, secs_on_m}) > int'($signed(cfg_m.min_on_seconds))) begin
              drive_m        = 1'b0;
              secs_off_m     = '0;
              r.switched_off = 1'b1;
            end else begin
              r.refused = 1'b1;
            end
          end
        end
      end
      hyst_pkg::CMD_TICK: begin
        if (secs_on_m != TMR_MAX) secs_on_m = secs_on_m + 1'b1;
        if (secs_off_m != TMR_MAX) secs_off_m = secs_off_m + 1'b1;
      end
      hyst_pkg::CMD_ON: begin
        hold_m        = 1'b1;
        r.switched_on = !drive_m;
        drive_m       = 1'b1;
        secs_on_m     = '0;
      end
      hyst_pkg::CMD_OFF: begin
        hold_m         = 1'b1;
        r.switched_off = drive_m;
        drive_m        = 1'b0;
        secs_off_m     = '0;
      end
      hyst_pkg::CMD_AUTO: hold_m = 1'b0;
      default: ;
    endcase
    r.drive_on = drive_m;
    r.held     = hold_m;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one request; valid stays high after acceptance
  task automatic send_req(input logic [hyst_pkg::CMD_W-1:0] cmd,
                          input logic signed [hyst_pkg::TEMP_W-1:0] temp);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.temperature <= temp;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(thermo_predict(cmd, temp));
    n_sent++;
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [hyst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hyst_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all five registers; only called with the block drained
  task automatic load_config(input logic signed [hyst_pkg::TEMP_W-1:0] tgt,
                             input logic [hyst_pkg::BAND_W-1:0] band,
                             input logic mode,
                             input logic signed [hyst_pkg::MIN_W-1:0] min_on,
                             input logic signed [hyst_pkg::MIN_W-1:0] min_off);
    drain();
    cfg_write(hyst_pkg::REG_TARGET, {1'b0, tgt});
    cfg_write(hyst_pkg::REG_BAND, hyst_pkg::CFG_DATA_W'(band));
    cfg_write(hyst_pkg::REG_MODE, hyst_pkg::CFG_DATA_W'(mode));
    cfg_write(hyst_pkg::REG_MIN_ON, min_on);
    cfg_write(hyst_pkg::REG_MIN_OFF, min_off);
    cfg_ch.valid <= 1'b0;
    cfg_m.target_temp     = tgt;
    cfg_m.band_half_width = band;
    cfg_m.unit_mode       = mode;
    cfg_m.min_on_seconds  = min_on;
    cfg_m.min_off_seconds = min_off;
  endtask

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 5) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_r = '{out_ch.drive_on, out_ch.switched_on, out_ch.switched_off,
                out_ch.refused, out_ch.held};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        expected_r = pending_results.pop_front();
        n_checked++;
        for (int i = 0; i < 5; i++) begin
          if (got_r[i] !== expected_r[i])
            report_mismatch($sformatf("%s got %b want %b", field_names[i], got_r[i],
                                      expected_r[i]));
        end
        n_sw_on   += expected_r.switched_on;
        n_sw_off  += expected_r.switched_off;
        n_refused += expected_r.refused;
        n_held    += expected_r.held;
      end
    end
  end

  // Default config: heat below 304, stop above 336, no minimum times
  task automatic test_reset_defaults();
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd300);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd320);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd340);
    send_req(hyst_pkg::CMD_SAMPLE, -16'sd32768);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd32767);
    send_req(CMD_LAST_UNDEF, 16'sd0);
  endtask

  // Manual on/off, repeated commands, sample under hold, return to automatic
  task automatic test_manual();
    send_req(hyst_pkg::CMD_ON, 16'sd0);
    send_req(hyst_pkg::CMD_ON, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd32767);
    send_req(hyst_pkg::CMD_AUTO, 16'sd0);
    send_req(hyst_pkg::CMD_OFF, 16'sd0);
    send_req(hyst_pkg::CMD_OFF, 16'sd0);
    send_req(hyst_pkg::CMD_AUTO, 16'sd0);
  endtask

  // Cooling unit with minimum on and off times: refusals, then switches
  task automatic test_min_times();
    load_config(16'sd0, 12'd2, hyst_pkg::MODE_COOL, 17'sd2, 17'sd3);
    send_req(hyst_pkg::CMD_OFF, 16'sd0);
    send_req(hyst_pkg::CMD_AUTO, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd10);
    repeat (3) send_req(hyst_pkg::CMD_TICK, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd10);
    send_req(hyst_pkg::CMD_TICK, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd10);
    send_req(hyst_pkg::CMD_SAMPLE, -16'sd10);
    repeat (3) send_req(hyst_pkg::CMD_TICK, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, -16'sd10);
  endtask

  // A minimum off time of 65534 keeps refusing the switch-on while ticks go by
  task automatic test_saturation();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    load_config(16'sd0, 12'd0, MODE_HEAT, NO_MIN, MIN_TOP);
    send_req(hyst_pkg::CMD_OFF, 16'sd0);
    send_req(hyst_pkg::CMD_AUTO, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, -16'sd5);
    repeat (16) send_req(hyst_pkg::CMD_TICK, 16'sd0);
    send_req(hyst_pkg::CMD_SAMPLE, -16'sd5);
    send_req(hyst_pkg::CMD_SAMPLE, 16'sd5);
    drain();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Receiver holds off while the sender keeps pushing requests
  task automatic test_backpressure();
    drain();
    src_idle  = 1'b0;
    sink_hold = 40;
    repeat (30) send_req(($urandom_range(0, 1) != 0) ? hyst_pkg::CMD_TICK
                                                     : hyst_pkg::CMD_SAMPLE,
                         hyst_pkg::TEMP_W'($urandom_range(0, 1000)));
    drain();
    src_idle = 1'b1;
  endtask

  // Random phases: a config per phase, mostly samples near the band and ticks
  task automatic test_random_phases(input int n_phases, input int per_phase);
    logic signed [hyst_pkg::TEMP_W-1:0] tgt;
    logic [hyst_pkg::BAND_W-1:0]        band;
    logic signed [hyst_pkg::MIN_W-1:0]  min_on;
    logic signed [hyst_pkg::MIN_W-1:0]  min_off;
    int                                 done;
    int                                 pick;
    int                                 span;
    int                                 t_val;
    for (int ph = 0; ph < n_phases; ph++) begin
      if (ph == 0) begin
        load_config(16'sd32767, 12'd4095, hyst_pkg::MODE_COOL, 17'sd0, NO_MIN);
      end else if (ph == 1) begin
        load_config(-16'sd32768, 12'd0, MODE_HEAT, NO_MIN, 17'sd0);
      end else begin
        tgt     = hyst_pkg::TEMP_W'($urandom_range(0, 4000)) - 16'sd2000;
        band    = ($urandom_range(0, 7) == 0) ? hyst_pkg::BAND_W'($urandom)
                                              : hyst_pkg::BAND_W'($urandom_range(0, 64));
        min_on  = ($urandom_range(0, 9) == 0) ? MIN_TOP
                                              : hyst_pkg::MIN_W'($urandom_range(0, 7)) - 17'sd1;
        min_off = ($urandom_range(0, 9) == 0) ? MIN_TOP
                                              : hyst_pkg::MIN_W'($urandom_range(0, 7)) - 17'sd1;
        load_config(tgt, band, 1'($urandom), min_on, min_off);
      end
      // Phase 2 always runs without any idling on either side
      src_idle  = (ph != 2) && ($urandom_range(0, 3) != 0);
      sink_idle = (ph != 2) && ($urandom_range(0, 3) != 0);
      span      = int'(cfg_m.band_half_width) + 8;
      done      = 0;
      while (done < per_phase) begin
        pick  = $urandom_range(0, 99);
        t_val = int'($signed(cfg_m.target_temp)) + $urandom_range(0, 2 * span) - span;
        if (t_val > 32767) t_val = 32767;
        if (t_val < -32768) t_val = -32768;
        if (pick < 45) send_req(hyst_pkg::CMD_SAMPLE, hyst_pkg::TEMP_W'(t_val));
        else if (pick < 75) send_req(hyst_pkg::CMD_TICK, hyst_pkg::TEMP_W'($urandom));
        else if (pick < 80) send_req(hyst_pkg::CMD_SAMPLE, hyst_pkg::TEMP_W'($urandom));
        else if (pick < 85) send_req(hyst_pkg::CMD_ON, hyst_pkg::TEMP_W'($urandom));
        else if (pick < 90) send_req(hyst_pkg::CMD_OFF, hyst_pkg::TEMP_W'($urandom));
        else if (pick < 97) send_req(hyst_pkg::CMD_AUTO, hyst_pkg::TEMP_W'($urandom));
        else send_req(hyst_pkg::CMD_W'($urandom_range(hyst_pkg::CMD_AUTO + 1, CMD_LAST_UNDEF)),
                      hyst_pkg::TEMP_W'($urandom));
        if (pick < 97) done++;
      end
    end
    drain();
  endtask

  initial begin
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= hyst_pkg::CMD_SAMPLE;
    in_ch.temperature <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= hyst_pkg::REG_TARGET;
    cfg_ch.data       <= '0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    sink_hold = 0;
    cfg_m.target_temp     = hyst_pkg::TARGET_RST;
    cfg_m.band_half_width = hyst_pkg::BAND_RST;
    cfg_m.unit_mode       = hyst_pkg::MODE_RST;
    cfg_m.min_on_seconds  = hyst_pkg::MIN_RST;
    cfg_m.min_off_seconds = hyst_pkg::MIN_RST;
    drive_m    = 1'b0;
    hold_m     = 1'b0;
    secs_on_m  = TMR_W'(1);
    secs_off_m = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_manual();
    test_min_times();
    test_saturation();
    test_backpressure();
    test_random_phases(6, 70);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests, checked %0d results under %0s idling and a long output stall.",
             n_sent, n_checked, "random");
    $display("Results held %0d switch-ons, %0d switch-offs, %0d refusals, %0d under hold.",
             n_sw_on, n_sw_off, n_refused, n_held);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hyst_pkg.sv
rtl/hyst_in_if.sv
rtl/hyst_out_if.sv
rtl/hyst_cfg_if.sv
rtl/hyst_core.sv
rtl/hysteresis_thermostat_min_cycle_top.sv
tb/tb_top.sv
